>>> rtl/pmd_pkg.sv
`timescale 1ns / 1ps

package pmd_pkg;

  // Default number of motor channels.
  localparam int CHANNELS_DEF = 2;

  // Field and datapath widths.
  localparam int MEAS_W     = 32;
  localparam int ERR_W      = 33;
  localparam int DIFF_W     = 34;
  localparam int ACC_W      = 17;
  localparam int OPM_W      = 34;
  localparam int GAIN_W     = 16;
  localparam int PROD_W     = OPM_W + GAIN_W;
  localparam int SUM_W      = 45;
  localparam int QUO_W      = 44;
  localparam int MAG_W      = 16;
  localparam int PCT_W      = 7;
  localparam int WL_W       = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int OUT_DATA_W = 24;

  // Divide-by-100 unit: radix 16, one digit per cycle.
  localparam int DIGIT_BITS = 4;
  localparam int DIV_DIGITS = 13;
  localparam int DIV_W      = DIGIT_BITS * DIV_DIGITS;
  localparam int DIV_CNT_W  = 4;
  localparam int REM_W      = 7;
  localparam logic [REM_W-1:0] DIVISOR = 7'd100;

  // Arithmetic constants.
  localparam logic signed [ERR_W-1:0] DEADBAND = 33'sd10;
  localparam logic [9:0]        POS_GAIN     = 10'd1000;
  localparam logic [SUM_W-1:0]  POS_SAT_IN   = 45'd66;
  localparam logic [MAG_W-1:0]  MAG_MAX      = 16'hFFFF;
  localparam logic [PCT_W-1:0]  PCT_MAX      = 7'd100;
  localparam logic [WL_W-1:0]   ACC_LIMIT    = 17'd65535;

  // Reset values of the configuration registers.
  localparam logic [GAIN_W-1:0] P_GAIN_RST  = 16'd1000;
  localparam logic [GAIN_W-1:0] I_GAIN_RST  = 16'd1;
  localparam logic [GAIN_W-1:0] D_GAIN_RST  = 16'd50;
  localparam logic [WL_W-1:0]   WINDUP_RST  = 17'd200;
  localparam logic [PCT_W-1:0]  MAX_PCT_RST = 7'd100;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE    = 3'd0,
    REG_P_GAIN  = 3'd1,
    REG_I_GAIN  = 3'd2,
    REG_D_GAIN  = 3'd3,
    REG_WINDUP  = 3'd4,
    REG_MAX_PCT = 3'd5
  } cfg_reg_t;

  // Operand selection for the shared multiplier.
  typedef enum logic [1:0] {
    TERM_P,
    TERM_I,
    TERM_D,
    TERM_S
  } term_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_MUL_P,
    ST_DIV_P,
    ST_MUL_I,
    ST_DIV_I,
    ST_MUL_D,
    ST_DIV_D,
    ST_SAT,
    ST_MUL_S,
    ST_DIV_S,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  load;
    logic  acc_upd;
    logic  zero_drive;
    logic  mul;
    term_t term;
    logic  accum;
    logic  sat;
    logic  scale_wr;
    logic  out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mode;
    logic tgt_zero;
    logic div_done;
  } dp_sts_t;

endpackage

>>> rtl/pid_motor_drive_top.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake              Payload
// in_       in   in_tvalid/in_tready    measured, target (tdata); channel (tuser)
// out_      out  out_tvalid/out_tready  pwm_value, backward (tdata); out_channel (tuser)
// cfg_      in   cfg_we                 cfg_idx selects the register, cfg_data the value
//
// The result is offered in the same cycle in which the block is ready again.
// Each word runs through the single multiplier and the radix-16 divide-by-100
// unit, used for the P, I and D terms and, in position mode, for the percent
// scaling; in speed mode a zero target skips them and sets a zero magnitude.
// rst_n is synchronous and clears the loop state of every channel and the
// configuration to its defaults. A stalled output word is held in the output
// register while the next word is accepted and computed; the controller waits
// in its final state until that register is free.

module pid_motor_drive_top
  import pmd_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Input stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [2*MEAS_W-1:0]   in_tdata,   // measured [31:0], target [63:32]
  input  logic                  in_tuser,   // channel [0]
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // pwm_value [15:0], backward [16], zero [23:17]
  output logic                  out_tuser   // out_channel [0]
);

  dp_cmd_t          cmd;
  dp_sts_t          sts;
  logic [MAG_W-1:0] pwm_value;
  logic             backward;

  // Sequencer.
  pmd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Arithmetic, loop state and output register.
  pmd_datapath #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_data    (cfg_data),
    .measured    (in_tdata[MEAS_W-1:0]),
    .target      (in_tdata[2*MEAS_W-1:MEAS_W]),
    .channel     (in_tuser),
    .cmd         (cmd),
    .sts         (sts),
    .pwm_value   (pwm_value),
    .backward    (backward),
    .out_channel (out_tuser)
  );

  assign out_tdata = {{(OUT_DATA_W-MAG_W-1){1'b0}}, backward, pwm_value};

endmodule

>>> rtl/pmd_div100.sv
`timescale 1ns / 1ps

module pmd_div100
  import pmd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  logic [DIV_W-1:0] dividend,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic [DIV_W-1:0]     dvd_r, dvd_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;

  // One radix-16 digit: four restoring compare-subtract steps on the remainder.
  // Quotient bits shift in at the bottom as dividend bits leave the top.
  always_comb begin
    logic [REM_W:0] trial;
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    for (int k = 0; k < DIGIT_BITS; k++) begin
      trial   = {rem_nxt, dvd_nxt[DIV_W-1]};
      dvd_nxt = {dvd_nxt[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, DIVISOR}) begin
        rem_nxt    = REM_W'(trial - {1'b0, DIVISOR});
        dvd_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial[REM_W-1:0];
      end
    end
  end

  // Digit counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= DIV_CNT_W'(DIV_DIGITS);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // Dividend, quotient and remainder registers.
  always_ff @(posedge clk) begin
    if (load) begin
      dvd_r <= dividend;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = (cnt_r == '0);
  assign quotient = dvd_r;

endmodule

>>> rtl/pmd_datapath.sv
`timescale 1ns / 1ps

module pmd_datapath
  import pmd_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [MEAS_W-1:0]     measured,
  input  logic [MEAS_W-1:0]     target,
  input  logic                  channel,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  output logic [MAG_W-1:0]      pwm_value,
  output logic                  backward,
  output logic                  out_channel
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

  // Configuration registers.
  logic              mode_r;
  logic [GAIN_W-1:0] p_gain_r, i_gain_r, d_gain_r;
  logic [WL_W-1:0]   windup_r;
  logic [PCT_W-1:0]  max_pct_r;

  // Per-channel loop state.
  logic signed [ACC_W-1:0] acc_mem_r  [CHANNELS];
  logic signed [ERR_W-1:0] prev_mem_r [CHANNELS];

  // Working registers for the current word.
  logic [CH_W-1:0]          ch_r;
  logic                     chin_r;
  logic                     tgt_zero_r;
  logic signed [ERR_W-1:0]  err_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic                     neg_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic [MAG_W-1:0]         mag_r;
  logic                     back_r;

  // Output register.
  logic [MAG_W-1:0] pwm_r;
  logic             bk_out_r;
  logic             chan_out_r;

  logic [CH_W-1:0]          ch_in;
  logic signed [ERR_W-1:0]  err_raw, err_db;
  logic [WL_W-1:0]          lim;
  logic signed [DIFF_W-1:0] acc_sum, lim_s;
  logic signed [ACC_W-1:0]  acc_new;
  logic signed [DIFF_W-1:0] diff_new;
  logic [PCT_W-1:0]         pct;
  logic [OPM_W-1:0]         op_mag;
  logic                     op_neg;
  logic [GAIN_W-1:0]        op_gain;
  logic [PROD_W-1:0]        product;
  logic                     div_done;
  logic [DIV_W-1:0]         quotient;
  logic signed [SUM_W-1:0]  term_val;
  logic [SUM_W-1:0]         abs_sum;
  logic [MAG_W-1:0]         sat_mag;
  logic [16:0]              pos_mag;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b0;
      p_gain_r  <= P_GAIN_RST;
      i_gain_r  <= I_GAIN_RST;
      d_gain_r  <= D_GAIN_RST;
      windup_r  <= WINDUP_RST;
      max_pct_r <= MAX_PCT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_MODE:    mode_r    <= cfg_data[0];
        REG_P_GAIN:  p_gain_r  <= cfg_data[GAIN_W-1:0];
        REG_I_GAIN:  i_gain_r  <= cfg_data[GAIN_W-1:0];
        REG_D_GAIN:  d_gain_r  <= cfg_data[GAIN_W-1:0];
        REG_WINDUP:  windup_r  <= cfg_data[WL_W-1:0];
        REG_MAX_PCT: max_pct_r <= cfg_data[PCT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Channel select, error and deadband.
  always_comb begin
    if (32'(channel) < CHANNELS) begin
      ch_in = CH_W'(channel);
    end else begin
      ch_in = LAST_CH;
    end
    err_raw = $signed({target[MEAS_W-1], target}) - $signed({measured[MEAS_W-1], measured});
    err_db  = err_raw;
    if (!mode_r && (err_raw > -DEADBAND) && (err_raw < DEADBAND)) begin
      err_db = '0;
    end
  end

  // Integral update with the combined clamp, and the error difference.
  always_comb begin
    lim     = (windup_r > ACC_LIMIT) ? ACC_LIMIT : windup_r;
    lim_s   = $signed({{(DIFF_W-WL_W){1'b0}}, lim});
    acc_sum = $signed({{(DIFF_W-ACC_W){acc_mem_r[ch_r][ACC_W-1]}}, acc_mem_r[ch_r]})
            + $signed({err_r[ERR_W-1], err_r});
    if (acc_sum > lim_s) begin
      acc_new = $signed(lim);
    end else if (acc_sum < -lim_s) begin
      acc_new = -$signed(lim);
    end else begin
      acc_new = acc_sum[ACC_W-1:0];
    end
    diff_new = $signed({err_r[ERR_W-1], err_r})
             - $signed({prev_mem_r[ch_r][ERR_W-1], prev_mem_r[ch_r]});
  end

  // Shared multiplier on magnitudes; the sign travels separately.
  always_comb begin
    logic signed [DIFF_W-1:0] e_ext, a_ext;
    e_ext = $signed({err_r[ERR_W-1], err_r});
    a_ext = $signed({{(DIFF_W-ACC_W){acc_r[ACC_W-1]}}, acc_r});
    pct   = (max_pct_r > PCT_MAX) ? PCT_MAX : max_pct_r;
    unique case (cmd.term)
      TERM_P: begin
        op_neg  = err_r[ERR_W-1];
        op_mag  = op_neg ? OPM_W'(-e_ext) : OPM_W'(e_ext);
        op_gain = p_gain_r;
      end
      TERM_I: begin
        op_neg  = acc_r[ACC_W-1];
        op_mag  = op_neg ? OPM_W'(-a_ext) : OPM_W'(a_ext);
        op_gain = i_gain_r;
      end
      TERM_D: begin
        op_neg  = diff_r[DIFF_W-1];
        op_mag  = op_neg ? OPM_W'(-diff_r) : OPM_W'(diff_r);
        op_gain = d_gain_r;
      end
      TERM_S: begin
        op_neg  = 1'b0;
        op_mag  = OPM_W'(mag_r);
        op_gain = GAIN_W'(pct);
      end
      default: begin
        op_neg  = 1'b0;
        op_mag  = '0;
        op_gain = '0;
      end
    endcase
    product = op_mag * op_gain;
  end

  // The divider's dividend register is the register after the multiplier.
  pmd_div100 u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (cmd.mul),
    .dividend (DIV_W'(product)),
    .done     (div_done),
    .quotient (quotient)
  );

  // Signed quotient, and saturation of the PID sum.
  always_comb begin
    term_val = $signed({1'b0, quotient[QUO_W-1:0]});
    if (neg_r) begin
      term_val = -term_val;
    end
    abs_sum = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
    pos_mag = 17'(abs_sum[6:0] * POS_GAIN);
    if (!mode_r) begin
      // Times 1000 overflows the magnitude once the sum reaches 66.
      sat_mag = (abs_sum >= POS_SAT_IN) ? MAG_MAX : pos_mag[MAG_W-1:0];
    end else begin
      sat_mag = (abs_sum > SUM_W'(MAG_MAX)) ? MAG_MAX : abs_sum[MAG_W-1:0];
    end
  end

  // Per-channel state, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CHANNELS; k++) begin
        acc_mem_r[k]  <= '0;
        prev_mem_r[k] <= '0;
      end
    end else if (cmd.acc_upd) begin
      acc_mem_r[ch_r]  <= acc_new;
      prev_mem_r[ch_r] <= err_r;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch_r       <= ch_in;
      chin_r     <= channel;
      tgt_zero_r <= (target == '0);
      err_r      <= err_db;
      sum_r      <= '0;
    end
    if (cmd.acc_upd) begin
      acc_r  <= acc_new;
      diff_r <= diff_new;
    end
    if (cmd.mul) begin
      neg_r <= op_neg;
    end
    if (cmd.accum) begin
      sum_r <= sum_r + term_val;
    end
    if (cmd.sat) begin
      mag_r  <= sat_mag;
      back_r <= sum_r[SUM_W-1];
    end
    if (cmd.zero_drive) begin
      mag_r  <= '0;
      back_r <= 1'b0;
    end
    if (cmd.scale_wr) begin
      mag_r <= quotient[MAG_W-1:0];
    end
  end

  // Output register, low-active magnitude.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pwm_r      <= MAG_MAX - mag_r;
      bk_out_r   <= back_r;
      chan_out_r <= chin_r;
    end
  end

  assign sts.mode     = mode_r;
  assign sts.tgt_zero = tgt_zero_r;
  assign sts.div_done = div_done;

  assign pwm_value   = pwm_r;
  assign backward    = bk_out_r;
  assign out_channel = chan_out_r;

endmodule

>>> rtl/pmd_ctrl.sv
`timescale 1ns / 1ps

module pmd_ctrl
  import pmd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  logic    out_tready,
  output logic    out_tvalid,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  // State and output-valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.term  = TERM_P;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.load  = 1'b1;
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        if (sts.mode && sts.tgt_zero) begin
          cmd.zero_drive = 1'b1;
          state_nxt      = ST_DONE;
        end else begin
          cmd.acc_upd = 1'b1;
          state_nxt   = ST_MUL_P;
        end
      end
      ST_MUL_P: begin
        cmd.mul   = 1'b1;
        cmd.term  = TERM_P;
        state_nxt = ST_DIV_P;
      end
      ST_DIV_P: begin
        if (sts.div_done) begin
          cmd.accum = 1'b1;
          state_nxt = ST_MUL_I;
        end
      end
      ST_MUL_I: begin
        cmd.mul   = 1'b1;
        cmd.term  = TERM_I;
        state_nxt = ST_DIV_I;
      end
      ST_DIV_I: begin
        if (sts.div_done) begin
          cmd.accum = 1'b1;
          state_nxt = ST_MUL_D;
        end
      end
      ST_MUL_D: begin
        cmd.mul   = 1'b1;
        cmd.term  = TERM_D;
        state_nxt = ST_DIV_D;
      end
      ST_DIV_D: begin
        if (sts.div_done) begin
          cmd.accum = 1'b1;
          state_nxt = ST_SAT;
        end
      end
      ST_SAT: begin
        cmd.sat   = 1'b1;
        state_nxt = sts.mode ? ST_DONE : ST_MUL_S;
      end
      ST_MUL_S: begin
        cmd.mul   = 1'b1;
        cmd.term  = TERM_S;
        state_nxt = ST_DIV_S;
      end
      ST_DIV_S: begin
        if (sts.div_done) begin
          cmd.scale_wr = 1'b1;
          state_nxt    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The output word stays until taken, unless a new one replaces it.
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // A result never overwrites a word that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result loaded over a waiting output word");

  // A loaded result is offered in the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded result not presented");

  // The divider is busy right after it was loaded.
  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul |=> !sts.div_done)
    else $error("divider reports done right after load");

  // An accepted word always moves the controller into the integral state ST_ACC.
  a_accept_acc: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_ACC))
    else $error("accepted word did not start processing");

endmodule

>>> bench/pid_motor_drive_top_tb.sv
`timescale 1ns / 1ps

module pid_motor_drive_top_tb;
  import pmd_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_WORDS = 106;
  localparam int END_CYCLES  = 40;

  // Loop modes as the mode register encodes them.
  localparam logic MODE_POSITION = 1'b0;
  localparam logic MODE_SPEED    = 1'b1;

  // Register indexes past the last register; writes there must be ignored.
  localparam cfg_reg_t REG_SPARE_6 = cfg_reg_t'(3'd6);
  localparam cfg_reg_t REG_SPARE_7 = cfg_reg_t'(3'd7);

  localparam logic signed [MEAS_W-1:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [MEAS_W-1:0] S_MAX = 32'sh7FFF_FFFF;

  // One drive word as the block reports it.
  typedef struct packed {
    logic [MAG_W-1:0] pwm;
    logic             back;
    logic             chan;
  } drive_t;

  // One row of the directed plan: either a word or a register write.
  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t               kind;
    cfg_reg_t                idx;
    logic [CFG_DATA_W-1:0]   val;
    logic signed [MEAS_W-1:0] meas;
    logic signed [MEAS_W-1:0] tgt;
    logic                    chan;
    logic                    pinned;
    logic [MAG_W-1:0]        pwm;
    logic                    back;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [2*MEAS_W-1:0]   in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  // Copy of the configuration and of the per-channel loop state.
  logic                    cfg_mode;
  logic [GAIN_W-1:0]       gain_p;
  logic [GAIN_W-1:0]       gain_i;
  logic [GAIN_W-1:0]       gain_d;
  logic [WL_W-1:0]         windup;
  logic [PCT_W-1:0]        max_pct;
  logic signed [ACC_W-1:0] acc_err [CHANNELS_DEF];
  logic signed [ERR_W-1:0] last_err [CHANNELS_DEF];

  drive_t drive_q [$];
  row_t   plan [$];

  int  cycles = 0;
  int  fail_count;
  int  words_sent;
  int  words_checked;
  int  position_words;
  int  settings_loaded;
  logic calm = 1'b0;

  pid_motor_drive_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Runaway guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // One PID step on the selected channel, producing the expected drive word.
  function automatic drive_t predict_drive(logic signed [MEAS_W-1:0] meas,
                                           logic signed [MEAS_W-1:0] tgt, logic chan);
    drive_t res;
    longint err;
    longint acc;
    longint sum;
    longint drv;
    longint mag;
    longint pct;
    int     k;
    k = int'(chan);
    err = longint'(tgt) - longint'(meas);
    drv = 0;
    if (cfg_mode == MODE_POSITION && err > -10 && err < 10) err = 0;
    // A zero target in speed mode leaves the loop state alone.
    if (cfg_mode == MODE_POSITION || tgt != 0) begin
      acc = longint'(acc_err[k]) + err;
      if (acc > longint'(windup)) acc = longint'(windup);
      if (acc < -longint'(windup)) acc = -longint'(windup);
      if (acc > 65535) acc = 65535;
      if (acc < -65535) acc = -65535;
      sum = err * longint'(gain_p) / 100 + acc * longint'(gain_i) / 100
            + (err - longint'(last_err[k])) * longint'(gain_d) / 100;
      acc_err[k] = acc[ACC_W-1:0];
      last_err[k] = err[ERR_W-1:0];
      drv = (cfg_mode == MODE_POSITION) ? sum * 1000 : sum;
    end
    res.back = (drv < 0);
    mag = res.back ? -drv : drv;
    if (mag > 65535) mag = 65535;
    if (cfg_mode == MODE_POSITION) begin
      pct = (max_pct > 100) ? 100 : longint'(max_pct);
      mag = mag * pct / 100;
    end
    res.pwm = 16'hFFFF - mag[MAG_W-1:0];
    res.chan = chan;
    return res;
  endfunction

  // Directed plan rows.
  function automatic row_t word_row(logic signed [MEAS_W-1:0] m, logic signed [MEAS_W-1:0] t,
                                    logic c);
    row_t r;
    r = '{kind: ROW_WORD, idx: REG_MODE, val: '0, meas: m, tgt: t, chan: c,
          pinned: 1'b0, pwm: '0, back: 1'b0};
    return r;
  endfunction

  function automatic row_t pinned_row(logic signed [MEAS_W-1:0] m,
                                      logic signed [MEAS_W-1:0] t, logic c,
                                      logic [MAG_W-1:0] pwm, logic back);
    row_t r;
    r = word_row(m, t, c);
    r.pinned = 1'b1;
    r.pwm = pwm;
    r.back = back;
    return r;
  endfunction

  function automatic row_t reg_row(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    row_t r;
    r = word_row('0, '0, 1'b0);
    r.kind = ROW_REG;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  // Write one register and mirror it; the write enable drops before the next write.
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_MODE:    cfg_mode = val[0];
      REG_P_GAIN:  gain_p = val[GAIN_W-1:0];
      REG_I_GAIN:  gain_i = val[GAIN_W-1:0];
      REG_D_GAIN:  gain_d = val[GAIN_W-1:0];
      REG_WINDUP:  windup = val[WL_W-1:0];
      REG_MAX_PCT: max_pct = val[PCT_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Stop sending and wait until every expected word has come back.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Offer one word; valid stays high so that the next word can follow at once.
  task automatic push_word(logic signed [MEAS_W-1:0] m, logic signed [MEAS_W-1:0] t,
                           logic c, logic pinned, logic [MAG_W-1:0] pwm, logic back);
    drive_t exp_drive;
    int     gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {t, m};
    in_tuser <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (cfg_mode == MODE_POSITION) position_words++;
    exp_drive = predict_drive(m, t, c);
    if (pinned) begin
      exp_drive.pwm = pwm;
      exp_drive.back = back;
    end
    drive_q.push_back(exp_drive);
    words_sent++;
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return 16'hFFFF;
    if (r < 70) return GAIN_W'($urandom_range(0, 300));
    return GAIN_W'($urandom_range(0, 65535));
  endfunction

  task automatic load_random_settings();
    int r;
    logic [CFG_DATA_W-1:0] wl;
    logic [CFG_DATA_W-1:0] pct;
    r = $urandom_range(0, 99);
    if (r < 15) wl = '0;
    else if (r < 30) wl = 17'h1FFFF;
    else if (r < 40) wl = 17'd65535;
    else if (r < 75) wl = CFG_DATA_W'($urandom_range(0, 500));
    else wl = CFG_DATA_W'($urandom_range(0, 131071));
    r = $urandom_range(0, 99);
    if (r < 15) pct = '0;
    else if (r < 35) pct = 17'd100;
    else if (r < 45) pct = 17'd127;
    else pct = CFG_DATA_W'($urandom_range(0, 127));
    write_reg(REG_MODE, CFG_DATA_W'($urandom_range(0, 1)));
    write_reg(REG_P_GAIN, CFG_DATA_W'(pick_gain()));
    write_reg(REG_I_GAIN, CFG_DATA_W'(pick_gain()));
    write_reg(REG_D_GAIN, CFG_DATA_W'(pick_gain()));
    write_reg(REG_WINDUP, wl);
    write_reg(REG_MAX_PCT, pct);
    settings_loaded++;
  endtask

  function automatic logic signed [MEAS_W-1:0] corner_value();
    case ($urandom_range(0, 4))
      0: return S_MIN;
      1: return S_MAX;
      2: return '0;
      3: return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  // Random word: mostly errors near the deadband or moderate, some full range.
  task automatic random_word(output logic signed [MEAS_W-1:0] m,
                             output logic signed [MEAS_W-1:0] t, output logic c);
    int r;
    r = $urandom_range(0, 99);
    c = 1'($urandom_range(0, 1));
    if (r < 30) begin
      m = $urandom_range(0, 20000) - 10000;
      t = m + $urandom_range(0, 60) - 30;
    end else if (r < 55) begin
      m = $urandom_range(0, 200000) - 100000;
      t = $urandom_range(0, 200000) - 100000;
    end else if (r < 70) begin
      m = $urandom;
      t = $urandom;
    end else if (r < 80) begin
      m = (r < 75) ? $urandom_range(0, 2000) - 1000 : $urandom;
      t = '0;
    end else if (r < 90) begin
      m = corner_value();
      t = corner_value();
    end else begin
      m = $urandom;
      t = m + $urandom_range(0, 400) - 200;
    end
  endtask

  // Result side: random back-pressure.
  initial begin
    int n;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // Compare each delivered word with the oldest expectation.
  always @(posedge clk) begin
    drive_t exp_drive;
    if (rst_n && out_tvalid && out_tready) begin
      words_checked++;
      if (drive_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, got pwm %0d backward %0b channel %0b",
                 $time, out_tdata[MAG_W-1:0], out_tdata[MAG_W], out_tuser);
        fail_count++;
      end else begin
        exp_drive = drive_q.pop_front();
        if (out_tdata[MAG_W-1:0] !== exp_drive.pwm) begin
          $display("%0t: pwm_value expected %0d, got %0d", $time, exp_drive.pwm,
                   out_tdata[MAG_W-1:0]);
          fail_count++;
        end
        if (out_tdata[MAG_W] !== exp_drive.back) begin
          $display("%0t: backward expected %0b, got %0b", $time, exp_drive.back,
                   out_tdata[MAG_W]);
          fail_count++;
        end
        if (out_tuser !== exp_drive.chan) begin
          $display("%0t: out_channel expected %0b, got %0b", $time, exp_drive.chan, out_tuser);
          fail_count++;
        end
      end
    end
  end

  initial begin
    logic signed [MEAS_W-1:0] m;
    logic signed [MEAS_W-1:0] t;
    logic c;

    fail_count = 0;
    words_sent = 0;
    words_checked = 0;
    position_words = 0;
    settings_loaded = 0;
    cfg_mode = MODE_POSITION;
    gain_p = 16'd1000;
    gain_i = 16'd1;
    gain_d = 16'd50;
    windup = 17'd200;
    max_pct = 7'd100;
    foreach (acc_err[k]) begin
      acc_err[k] = '0;
      last_err[k] = '0;
    end

    // Defaults after reset: position loop, deadband, saturation both ways.
    plan.push_back(pinned_row(0, 0, 1'b0, 16'hFFFF, 1'b0));
    plan.push_back(pinned_row(0, 9, 1'b0, 16'hFFFF, 1'b0));
    plan.push_back(pinned_row(0, -9, 1'b1, 16'hFFFF, 1'b0));
    plan.push_back(pinned_row(0, 10, 1'b0, 16'h0000, 1'b0));
    plan.push_back(pinned_row(S_MIN, S_MAX, 1'b1, 16'h0000, 1'b0));
    plan.push_back(pinned_row(S_MAX, S_MIN, 1'b1, 16'h0000, 1'b1));
    plan.push_back(word_row(100, 0, 1'b0));
    // Percent scaling, including a value above 100 and zero.
    plan.push_back(reg_row(REG_MAX_PCT, 17'd50));
    plan.push_back(word_row(0, 1000, 1'b0));
    plan.push_back(reg_row(REG_MAX_PCT, 17'd127));
    plan.push_back(word_row(0, 1000, 1'b0));
    plan.push_back(reg_row(REG_MAX_PCT, 17'd0));
    plan.push_back(word_row(0, 5000, 1'b1));
    plan.push_back(reg_row(REG_MAX_PCT, 17'd100));
    // Windup limit above the hard clamp, then zero.
    plan.push_back(reg_row(REG_WINDUP, 17'h1FFFF));
    plan.push_back(reg_row(REG_I_GAIN, 17'd65535));
    plan.push_back(reg_row(REG_P_GAIN, 17'd0));
    plan.push_back(reg_row(REG_D_GAIN, 17'd0));
    plan.push_back(word_row(0, 100000, 1'b0));
    plan.push_back(word_row(0, 100000, 1'b0));
    plan.push_back(reg_row(REG_WINDUP, 17'd0));
    plan.push_back(word_row(5, 0, 1'b1));
    // Speed loop with full gains; a zero target drives nothing.
    plan.push_back(reg_row(REG_MODE, 17'(MODE_SPEED)));
    plan.push_back(reg_row(REG_P_GAIN, 17'd65535));
    plan.push_back(reg_row(REG_D_GAIN, 17'd65535));
    plan.push_back(reg_row(REG_WINDUP, 17'h1FFFF));
    plan.push_back(pinned_row(123, 0, 1'b0, 16'hFFFF, 1'b0));
    plan.push_back(pinned_row(0, 0, 1'b1, 16'hFFFF, 1'b0));
    plan.push_back(word_row(S_MIN, S_MAX, 1'b0));
    plan.push_back(word_row(0, 1, 1'b0));
    // All gains zero: the sum is zero and counts as forward.
    plan.push_back(reg_row(REG_P_GAIN, 17'd0));
    plan.push_back(reg_row(REG_I_GAIN, 17'd0));
    plan.push_back(reg_row(REG_D_GAIN, 17'd0));
    plan.push_back(pinned_row(5, 7, 1'b1, 16'hFFFF, 1'b0));
    plan.push_back(pinned_row(7, 5, 1'b1, 16'hFFFF, 1'b0));
    // Writes past the last register change nothing.
    plan.push_back(reg_row(REG_SPARE_6, 17'h1FFFF));
    plan.push_back(reg_row(REG_SPARE_7, 17'h1FFFF));
    plan.push_back(pinned_row(7, 5, 1'b0, 16'hFFFF, 1'b0));
    // Truncation toward zero on both signs.
    plan.push_back(reg_row(REG_P_GAIN, 17'd1));
    plan.push_back(word_row(0, -250, 1'b0));
    plan.push_back(word_row(0, 250, 1'b1));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[n]) begin
      if (plan[n].kind == ROW_REG) begin
        settle();
        write_reg(plan[n].idx, plan[n].val);
      end else begin
        push_word(plan[n].meas, plan[n].tgt, plan[n].chan, plan[n].pinned,
                  plan[n].pwm, plan[n].back);
      end
    end

    // Random phases, each under fresh settings; two of them run without gaps.
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      settle();
      load_random_settings();
      calm = (phase == 2 || phase == 5);
      repeat (PHASE_WORDS) begin
        random_word(m, t, c);
        push_word(m, t, c, 1'b0, '0, 1'b0);
      end
    end

    in_tvalid <= 1'b0;
    calm = 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (drive_q.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, drive_q.size());
      fail_count++;
    end

    $display("Sent %0d words (%0d in position mode) under %0d random register settings;",
             words_sent, position_words, settings_loaded);
    $display("checked %0d drive words, %0d mismatches.", words_checked, fail_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/pmd_pkg.sv
rtl/pmd_div100.sv
rtl/pmd_datapath.sv
rtl/pmd_ctrl.sv
rtl/pid_motor_drive_top.sv
bench/pid_motor_drive_top_tb.sv
